// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the filter rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CAFF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CAFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/caff_pkg.sv =====
// shared types and constants of the allow-list forwarding filter
// no dependencies; imported by every rtl module
package caff_pkg;

  typedef enum logic [1:0] {
    REQ_CHECK      = 2'd0,
    REQ_GRANT      = 2'd1,
    REQ_REVOKE     = 2'd2,
    REQ_REVOKE_ALL = 2'd3
  } caff_req_t;

  localparam logic [1:0] VERDICT_DROP      = 2'd0;
  localparam logic [1:0] VERDICT_FORWARD   = 2'd1;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_AUTH   = 2'd1;
  localparam logic [1:0] EV_DEAUTH = 2'd2;

  localparam logic [31:0] SUBNET_MASK     = 32'hFFFF_FF00;
  localparam logic [15:0] PORT_HTTP       = 16'd80;
  localparam logic [15:0] PORT_PORTAL     = 16'd2121;
  localparam logic [15:0] PORT_API        = 16'd4869;
  localparam logic [15:0] MINER_PORT_RST  = 16'd3333;
  localparam logic [15:0] MIN_IP_LEN      = 16'd20;
  localparam logic [15:0] MIN_TCP_LEN     = 16'd40;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;

  localparam int          CFG_ADDR_W      = 3;
  localparam logic        REG_AP_ADDRESS  = 1'b0;
  localparam logic        REG_MINER_PORT  = 1'b1;

  typedef struct packed {
    logic load;
    logic look;
    logic decide;
    logic drain_load;
  } caff_cmd_t;

  typedef struct packed {
    caff_req_t req_type;
    logic      tbl_empty;
    logic      drain_last;
  } caff_sts_t;

endpackage

// ===== rtl/core/caff_req_if.sv =====
// request channel of the filter: valid/ready plus request payload
// no dependencies
interface caff_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] peer_ip;
  logic [15:0] segment_len;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  protocol;
  logic [15:0] dest_port;

  modport source (
    output valid, req_type, peer_ip, segment_len, src_ip, dst_ip, protocol, dest_port,
    input  ready
  );
  modport sink (
    input  valid, req_type, peer_ip, segment_len, src_ip, dst_ip, protocol, dest_port,
    output ready
  );
endinterface

// ===== rtl/core/caff_res_if.sv =====
// result channel of the filter: valid/ready plus result payload
// no dependencies
interface caff_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [1:0]  op_status;
  logic [1:0]  auth_event;
  logic [31:0] event_ip;
  logic [4:0]  entry_count;
  logic        last;

  modport source (
    output valid, verdict, op_status, auth_event, event_ip, entry_count, last,
    input  ready
  );
  modport sink (
    input  valid, verdict, op_status, auth_event, event_ip, entry_count, last,
    output ready
  );
endinterface

// ===== rtl/core/caff_cfg.sv =====
// apb configuration registers: access point address and extra sandbox port
// depends on caff_pkg
module caff_cfg import caff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [31:0]           ap_address,
  output logic [15:0]           miner_port
);

  logic [31:0] ap_address_r;
  logic [15:0] miner_port_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_address_r <= '0;
      miner_port_r <= MINER_PORT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_AP_ADDRESS: ap_address_r <= pwdata;
        REG_MINER_PORT: miner_port_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_AP_ADDRESS: prdata = ap_address_r;
      REG_MINER_PORT: prdata = {16'd0, miner_port_r};
      default:        prdata = '0;
    endcase
  end

  assign ap_address = ap_address_r;
  assign miner_port = miner_port_r;

endmodule

// ===== rtl/core/caff_dp.sv =====
// datapath: request capture, allow table with parallel compare,
// verdict logic and result register; depends on caff_pkg
`include "assert_macros.svh"
module caff_dp import caff_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  caff_cmd_t   cmd,
  output caff_sts_t   sts,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_peer_ip,
  input  logic [15:0] in_segment_len,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] ap_address,
  input  logic [15:0] miner_port,
  output logic [1:0]  out_verdict,
  output logic [1:0]  out_op_status,
  output logic [1:0]  out_auth_event,
  output logic [31:0] out_event_ip,
  output logic [4:0]  out_entry_count,
  output logic        out_last
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // captured request
  caff_req_t   req_type_r;
  logic [31:0] peer_ip_r;
  logic [15:0] seg_len_r;
  logic [31:0] src_ip_r;
  logic [31:0] dst_ip_r;
  logic [7:0]  protocol_r;
  logic [15:0] dest_port_r;

  // allow table
  logic [31:0]      entry_r [MAX_ENTRIES];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // lookup stage
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [31:0]            key;
  logic [IDX_W-1:0]       hit_slot;
  logic [CNT_W-1:0]       cnt_m1;
  logic                   hit_r;
  logic [IDX_W-1:0]       slot_r;
  logic [31:0]            last_ent_r;

  // revoke-all drain
  logic [IDX_W-1:0] drain_idx_r;
  logic [CNT_W-1:0] drain_n_r;

  // decision
  logic [15:0]      tcp_port;
  logic             port_ok;
  logic             sandbox_ok;
  logic [1:0]       judge;
  logic [1:0]       res_verdict;
  logic [1:0]       res_status;
  logic [1:0]       res_event;
  logic [31:0]      res_ip;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_wa;
  logic [31:0]      tbl_wd;
  logic [CNT_W+4:0] cnt_ext;

  // result register
  logic [1:0]  verdict_r;
  logic [1:0]  status_r;
  logic [1:0]  event_r;
  logic [31:0] event_ip_r;
  logic [4:0]  ecount_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r  <= caff_req_t'(in_req_type);
      peer_ip_r   <= in_peer_ip;
      seg_len_r   <= in_segment_len;
      src_ip_r    <= in_src_ip;
      dst_ip_r    <= in_dst_ip;
      protocol_r  <= in_protocol;
      dest_port_r <= in_dest_port;
    end
  end

  // parallel compare against all live entries, lowest slot wins
  assign key    = (req_type_r == REQ_CHECK) ? src_ip_r : peer_ip_r;
  assign cnt_m1 = count_r - CNT_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = (CNT_W'(i) < count_r) && (entry_r[i] == key);
    end
  end

  always_comb begin
    hit_slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_slot = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_r      <= |hit_vec;
      slot_r     <= hit_slot;
      last_ent_r <= entry_r[cnt_m1[IDX_W-1:0]];
    end
  end

  // packet verdict
  assign tcp_port   = (seg_len_r >= MIN_TCP_LEN) ? dest_port_r : 16'd0;
  assign port_ok    = (tcp_port == PORT_HTTP) || (tcp_port == PORT_PORTAL) ||
                      (tcp_port == PORT_API) || (tcp_port == miner_port);
  assign sandbox_ok = (dst_ip_r == ap_address) &&
                      (((protocol_r == PROTO_TCP) && port_ok) ||
                       (protocol_r == PROTO_UDP) || (protocol_r == PROTO_ICMP));

  always_comb begin
    priority if (seg_len_r < MIN_IP_LEN)                                  judge = VERDICT_MALFORMED;
    else if ((src_ip_r & SUBNET_MASK) != (ap_address & SUBNET_MASK))  judge = VERDICT_FORWARD;
    else if (hit_r)                                                   judge = VERDICT_FORWARD;
    else if (sandbox_ok)                                              judge = VERDICT_FORWARD;
    else                                                              judge = VERDICT_DROP;
  end

  always_comb begin
    res_verdict = VERDICT_DROP;
    res_status  = ST_DONE;
    res_event   = EV_NONE;
    res_ip      = '0;
    tbl_we      = 1'b0;
    tbl_wa      = slot_r;
    tbl_wd      = last_ent_r;
    count_nxt   = count_r;
    unique case (req_type_r)
      REQ_CHECK: begin
        res_verdict = judge;
      end
      REQ_GRANT: begin
        if (hit_r) begin
          res_status = ST_PRESENT;
        end else if (count_r >= CNT_W'(MAX_ENTRIES)) begin
          res_status = ST_FULL;
        end else begin
          tbl_we    = 1'b1;
          tbl_wa    = count_r[IDX_W-1:0];
          tbl_wd    = peer_ip_r;
          count_nxt = count_r + CNT_W'(1);
          res_event = EV_AUTH;
          res_ip    = peer_ip_r;
        end
      end
      REQ_REVOKE: begin
        if (!hit_r) begin
          res_status = ST_NOT_FOUND;
        end else begin
          // last entry fills the freed slot
          tbl_we    = 1'b1;
          count_nxt = cnt_m1;
          res_event = EV_DEAUTH;
          res_ip    = peer_ip_r;
        end
      end
      REQ_REVOKE_ALL: begin
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  assign cnt_ext = {5'd0, count_nxt};

  always_ff @(posedge clk) begin
    if (cmd.decide && tbl_we) entry_r[tbl_wa] <= tbl_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drain_idx_r <= '0;
      drain_n_r   <= '0;
    end else if (cmd.decide) begin
      count_r     <= count_nxt;
      drain_idx_r <= '0;
      drain_n_r   <= count_r;
    end else if (cmd.drain_load) begin
      drain_idx_r <= drain_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      verdict_r  <= res_verdict;
      status_r   <= res_status;
      event_r    <= res_event;
      event_ip_r <= res_ip;
      ecount_r   <= cnt_ext[4:0];
      last_r     <= 1'b1;
    end else if (cmd.drain_load) begin
      verdict_r  <= VERDICT_DROP;
      status_r   <= ST_DONE;
      event_r    <= EV_DEAUTH;
      event_ip_r <= entry_r[drain_idx_r];
      ecount_r   <= '0;
      last_r     <= sts.drain_last;
    end
  end

  assign sts.req_type   = req_type_r;
  assign sts.tbl_empty  = (count_r == '0);
  assign sts.drain_last = ((CNT_W'(drain_idx_r) + CNT_W'(1)) == drain_n_r);

  assign out_verdict     = verdict_r;
  assign out_op_status   = status_r;
  assign out_auth_event  = event_r;
  assign out_event_ip    = event_ip_r;
  assign out_entry_count = ecount_r;
  assign out_last        = last_r;

  `CAFF_ASSERT(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ENTRIES), "table count above capacity")

endmodule

// ===== rtl/core/caff_ctrl.sv =====
// controller: sequences capture, lookup, decision and result drain
// depends on caff_pkg
`include "assert_macros.svh"
module caff_ctrl import caff_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  caff_sts_t sts,
  output caff_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOK   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_WAIT   = 5'b10000
  } caff_state_t;

  caff_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.req_type == REQ_REVOKE_ALL && !sts.tbl_empty) begin
          state_nxt = S_DRAIN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_DRAIN: begin
        // one deauth request per cleared entry
        if (!out_valid_r || out_ready) begin
          cmd.drain_load = 1'b1;
          out_valid_nxt  = 1'b1;
          if (sts.drain_last) state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CAFF_ASSERT(a_idle_no_pending, in_ready, !out_valid_r, "ready while a result is pending")
  `CAFF_ASSERT_NXT(a_accept_to_look, in_valid && in_ready, state_r == S_LOOK, "accept did not start lookup")
  `CAFF_ASSERT_NXT(a_drain_end, cmd.drain_load && sts.drain_last, state_r == S_WAIT && out_valid_r, "drain did not end on last entry")

endmodule

// ===== rtl/core/captive_allowlist_forward_filter.sv =====
// captive portal allow-list filter, top level: apb registers, controller, datapath
// a result is registered via the compare and decide states after its request is accepted;
// a new request is taken only in idle, after that result is taken; revoke all gives one
// result per cycle after the first while out_ready holds, up to MAX_ENTRIES results
// reset: synchronous active-low rst_n empties the table and restores registers, no clearing pass
module captive_allowlist_forward_filter import caff_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  caff_req_if.sink              in_if,
  caff_res_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  caff_cmd_t   cmd;
  caff_sts_t   sts;
  logic [31:0] ap_address;
  logic [15:0] miner_port;

  caff_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ap_address (ap_address),
    .miner_port (miner_port)
  );

  caff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  caff_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_if.req_type),
    .in_peer_ip      (in_if.peer_ip),
    .in_segment_len  (in_if.segment_len),
    .in_src_ip       (in_if.src_ip),
    .in_dst_ip       (in_if.dst_ip),
    .in_protocol     (in_if.protocol),
    .in_dest_port    (in_if.dest_port),
    .ap_address      (ap_address),
    .miner_port      (miner_port),
    .out_verdict     (out_if.verdict),
    .out_op_status   (out_if.op_status),
    .out_auth_event  (out_if.auth_event),
    .out_event_ip    (out_if.event_ip),
    .out_entry_count (out_if.entry_count),
    .out_last        (out_if.last)
  );

endmodule
